FILE: src/mme_pkg.sv
// Shared constants, types and a helper function for the matrix multiply engine.
package mme_pkg;

   localparam int MAX_DIM     = 8;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int DIM_W       = 4;
   localparam int IDX_W       = 3;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(2 * STORE_DEPTH);
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = PROD_W + $clog2(MAX_DIM);
   localparam int CSR_W       = 32;
   localparam int REG_IDX_W   = 2;
   localparam int PADDR_W     = REG_IDX_W + 2;

   localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_INNER = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd2;

   typedef struct packed {
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] n;
      logic [DIM_W-1:0] o;
   } dims_type;

   typedef struct packed {
      logic             first_k;
      logic             last_k;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_elem;
   } tag_type;

   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              issue;
      logic [ADDR_W-1:0] left_addr;
      logic [ADDR_W-1:0] right_addr;
      tag_type           tag;
   } ctrl_cmd_type;

   typedef struct packed {
      logic advance;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage

FILE: src/mme_req_if.sv
// Input element channel: valid/ready handshake carrying one matrix element.
interface mme_req_if;
   import mme_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

FILE: src/mme_rsp_if.sv
// Result channel: valid/ready handshake carrying one product element and its position.
interface mme_rsp_if;
   import mme_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] product_value;
   logic [IDX_W-1:0]         product_row;
   logic [IDX_W-1:0]         product_col;
   logic                     last_element;

   modport source (output valid, output product_value, output product_row,
                   output product_col, output last_element, input ready);
   modport sink (input valid, input product_value, input product_row,
                 input product_col, input last_element, output ready);
endinterface

FILE: src/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/mme_csr.sv
// APB-style configuration registers holding the three matrix dimensions.
module mme_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mme_pkg::PADDR_W-1:0]   paddr,
   input  logic [mme_pkg::CSR_W-1:0]     pwdata,
   output logic [mme_pkg::CSR_W-1:0]     prdata,
   output logic                          pready,
   output mme_pkg::dims_type             dims,
   output logic                          cfg_clear
);
   import mme_pkg::*;

   logic [DIM_W-1:0]     rows_ff, rows_in;
   logic [DIM_W-1:0]     inner_ff, inner_in;
   logic [DIM_W-1:0]     cols_ff, cols_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_xfer;

   assign pready  = 1'b1;
   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_xfer = psel && penable && pwrite && pready;

   always_comb begin
      rows_in   = rows_ff;
      inner_in  = inner_ff;
      cols_in   = cols_ff;
      cfg_clear = 1'b0;
      prdata    = '0;
      unique case (reg_idx)
         REG_ROWS: begin
            prdata = CSR_W'(rows_ff);
            if (wr_xfer) begin
               rows_in   = pwdata[DIM_W-1:0];
               cfg_clear = 1'b1;
            end
         end
         REG_INNER: begin
            prdata = CSR_W'(inner_ff);
            if (wr_xfer) begin
               inner_in  = pwdata[DIM_W-1:0];
               cfg_clear = 1'b1;
            end
         end
         REG_COLS: begin
            prdata = CSR_W'(cols_ff);
            if (wr_xfer) begin
               cols_in   = pwdata[DIM_W-1:0];
               cfg_clear = 1'b1;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(MAX_DIM);
         inner_ff <= DIM_W'(MAX_DIM);
         cols_ff  <= DIM_W'(MAX_DIM);
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   assign dims.m = clamp_dim(rows_ff);
   assign dims.n = clamp_dim(inner_ff);
   assign dims.o = clamp_dim(cols_ff);
endmodule

FILE: src/mme_ctrl.sv
// Controller: load sequencing of both stores and issue of dot-product reads.
module mme_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  mme_pkg::dims_type        dims,
   input  logic                     cfg_clear,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mme_pkg::dp_status_type   status,
   output mme_pkg::ctrl_cmd_type    cmd
);
   import mme_pkg::*;

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_CALC = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] left_total;
   logic [CNT_W:0]   total;
   logic [CNT_W:0]   cnt_next;
   logic [CNT_W-1:0] right_off;
   logic [CNT_W-1:0] left_lin;
   logic [CNT_W-1:0] right_lin;
   logic             in_left;
   logic             req_xfer;
   logic             last_k;
   logic             last_c;
   logic             last_r;

   assign left_total = CNT_W'(dims.m) * CNT_W'(dims.n);
   assign total      = (CNT_W+1)'(left_total) + (CNT_W+1)'(CNT_W'(dims.n) * CNT_W'(dims.o));
   assign cnt_next   = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign right_off  = cnt_ff - left_total;
   assign in_left    = cnt_ff < left_total;
   assign left_lin   = CNT_W'(r_ff) * CNT_W'(dims.n) + CNT_W'(k_ff);
   assign right_lin  = CNT_W'(k_ff) * CNT_W'(dims.o) + CNT_W'(c_ff);
   assign last_k     = ({1'b0, k_ff} + DIM_W'(1)) == dims.n;
   assign last_c     = ({1'b0, c_ff} + DIM_W'(1)) == dims.o;
   assign last_r     = ({1'b0, r_ff} + DIM_W'(1)) == dims.m;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;

      cmd                = '0;
      cmd.wr_left        = req_xfer && in_left;
      cmd.wr_right       = req_xfer && !in_left;
      cmd.wr_addr        = in_left ? cnt_ff[ADDR_W-1:0] : right_off[ADDR_W-1:0];
      cmd.left_addr      = left_lin[ADDR_W-1:0];
      cmd.right_addr     = right_lin[ADDR_W-1:0];
      cmd.tag.first_k    = (k_ff == '0);
      cmd.tag.last_k     = last_k;
      cmd.tag.row        = r_ff;
      cmd.tag.col        = c_ff;
      cmd.tag.last_elem  = last_r && last_c;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (cnt_next == total) begin
                  cnt_in   = '0;
                  r_in     = '0;
                  c_in     = '0;
                  k_in     = '0;
                  state_in = ST_CALC;
               end else begin
                  cnt_in = cnt_next[CNT_W-1:0];
               end
            end
         end
         ST_CALC: begin
            if (status.advance) begin
               cmd.issue = 1'b1;
               if (!last_k) begin
                  k_in = k_ff + IDX_W'(1);
               end else begin
                  k_in = '0;
                  if (!last_c) begin
                     c_in = c_ff + IDX_W'(1);
                  end else begin
                     c_in = '0;
                     if (!last_r) begin
                        r_in = r_ff + IDX_W'(1);
                     end else begin
                        r_in     = '0;
                        state_in = ST_LOAD;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (cfg_clear) begin
         cnt_in   = '0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end
endmodule

FILE: src/mme_dp.sv
// Datapath: element stores, multiplier, accumulator, shift-saturate and result register.
module mme_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  mme_pkg::ctrl_cmd_type           cmd,
   output mme_pkg::dp_status_type          status,
   input  logic signed [mme_pkg::DATA_W-1:0] element_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [mme_pkg::DATA_W-1:0] product_value,
   output logic [mme_pkg::IDX_W-1:0]       product_row,
   output logic [mme_pkg::IDX_W-1:0]       product_col,
   output logic                            last_element
);
   import mme_pkg::*;

   logic                     adv;
   logic [DATA_W-1:0]        left_q;
   logic [DATA_W-1:0]        right_q;
   logic                     s1_v_ff;
   tag_type                  s1_tag_ff;
   logic                     s2_v_ff;
   tag_type                  s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  sum;
   logic signed [ACC_W-1:0]  shifted;
   logic [DATA_W-1:0]        sat;
   logic                     fits;
   logic                     done;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]         row_ff;
   logic [IDX_W-1:0]         col_ff;
   logic                     last_ff;

   assign adv            = !rsp_valid_ff || rsp_ready;
   assign status.advance = adv;

   mme_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_left_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_left),
      .wr_addr (cmd.wr_addr),
      .wr_data (element_value),
      .rd_en   (adv),
      .rd_addr (cmd.left_addr),
      .rd_data (left_q)
   );

   mme_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_right_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_right),
      .wr_addr (cmd.wr_addr),
      .wr_data (element_value),
      .rd_en   (adv),
      .rd_addr (cmd.right_addr),
      .rd_data (right_q)
   );

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign sum      = (s2_tag_ff.first_k ? '0 : acc_ff) + prod_ext;
   assign shifted  = sum >>> FRAC_BITS;
   assign fits     = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
   assign sat      = fits ? shifted[DATA_W-1:0] :
                     (shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});
   assign done     = adv && s2_v_ff && s2_tag_ff.last_k;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_v_ff <= cmd.issue;
            s2_v_ff <= s1_v_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= cmd.tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= $signed(left_q) * $signed(right_q);
         if (s2_v_ff) begin
            acc_ff <= sum;
         end
      end
      if (done) begin
         value_ff <= $signed(sat);
         row_ff   <= s2_tag_ff.row;
         col_ff   <= s2_tag_ff.col;
         last_ff  <= s2_tag_ff.last_elem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign product_value = value_ff;
   assign product_row   = row_ff;
   assign product_col   = col_ff;
   assign last_element  = last_ff;
endmodule

FILE: src/matrix_multiply_engine.sv
// Matrix multiply engine top level: stores both operands, then streams the product.
// Loading accepts one element per cycle; ready stays high until the last right element.
// The product is computed by one multiplier reading both stores once per cycle unless
// a held result stalls it: each result sums inner_n products, issued k by k in order.
// A run yields rows_m x cols_o results, row by row and column by column within a row.
// Synchronous reset sets all dimensions to 8, clears the load count and empties the output.
module matrix_multiply_engine (
   input  logic                          clock,
   input  logic                          reset,
   mme_req_if.sink                       req_chan,
   mme_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mme_pkg::PADDR_W-1:0]   paddr,
   input  logic [mme_pkg::CSR_W-1:0]     pwdata,
   output logic [mme_pkg::CSR_W-1:0]     prdata,
   output logic                          pready
);
   import mme_pkg::*;

   dims_type      dims;
   logic          cfg_clear;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   mme_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .dims      (dims),
      .cfg_clear (cfg_clear)
   );

   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .dims      (dims),
      .cfg_clear (cfg_clear),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mme_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .element_value (req_chan.element_value),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .product_value (rsp_chan.product_value),
      .product_row   (rsp_chan.product_row),
      .product_col   (rsp_chan.product_col),
      .last_element  (rsp_chan.last_element)
   );
endmodule

FILE: src/mme_checker.sv
// Port-level assertions for the matrix multiply engine, bound to the top level.
module mme_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mme_pkg::DATA_W-1:0]    rsp_value,
   input logic [mme_pkg::IDX_W-1:0]     rsp_row,
   input logic [mme_pkg::IDX_W-1:0]     rsp_col,
   input logic                          rsp_last
);
   import mme_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_row) &&
                                  $stable(rsp_col) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result offered right after last transfer of a run");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.product_value),
   .rsp_row   (rsp_chan.product_row),
   .rsp_col   (rsp_chan.product_col),
   .rsp_last  (rsp_chan.last_element)
);
